// ===== src/fglf_pkg.sv =====
// Shared types and constants for the fuel gauge level filter.
package fglf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 11;
    localparam int LEVEL_W    = 3;
    localparam int TIMER_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_THR    = 6;

    // Scan period in ticks, and the scan timer that counts it
    localparam int SCAN_PERIOD  = 200;
    localparam int SCAN_TIMER_W = 8;

    // Millivolt scaling: average * MV_SPAN / full scale, clipped at MV_MAX
    localparam int MV_SPAN   = 2000;
    localparam int MV_SPAN_W = 11;
    localparam int MV_MAX    = 2047;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEVEL0    = 3'd0,
        CFG_LEVEL1    = 3'd1,
        CFG_LEVEL2    = 3'd2,
        CFG_LEVEL3    = 3'd3,
        CFG_LEVEL4    = 3'd4,
        CFG_LEVEL5    = 3'd5,
        CFG_FAR_WAIT  = 3'd6,
        CFG_NEAR_WAIT = 3'd7
    } t_cfg_idx;

    typedef logic [NUM_THR-1:0][MV_W-1:0] t_thr;

    // Threshold reset values, level 0 in entry 0
    localparam t_thr THR_RESET = {11'd300, 11'd600, 11'd900, 11'd1200, 11'd1500, 11'd1800};
    localparam logic [TIMER_W-1:0] FAR_WAIT_RESET  = 16'd3000;
    localparam logic [TIMER_W-1:0] NEAR_WAIT_RESET = 16'd6000;

    // Input and result transactions
    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] shown_level;
        logic               low_fuel_warning;
        logic               last;
    } t_out;

    // Pending display write held by the back end
    typedef struct packed {
        logic               en;
        logic [LEVEL_W-1:0] level;
        logic               warn;
    } t_write;

    // Outcome of one display write request
    typedef struct packed {
        logic en;
        logic warn;
        logic flag;
    } t_disp;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MV,
        ST_SCALE,
        ST_VOLT,
        ST_VAVG,
        ST_DECIDE,
        ST_EMIT1,
        ST_EMIT2
    } t_back_state;

endpackage

// ===== src/fglf_window.sv =====
// Moving-window running sum over a memory, seeded by its first value.
module fglf_window #(
    parameter int DEPTH  = 20,
    parameter int DATA_W = 12,
    parameter int SUM_W  = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic [SUM_W-1:0]  o_sum
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd;
    logic              r_byp;
    logic [DATA_W-1:0] r_byp_val;
    logic [DATA_W-1:0] r_seed_val, n_seed_val;
    logic              r_seeded, n_seeded;
    logic [PW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [PW-1:0]     pos_inc;
    logic [DATA_W-1:0] old_val;
    logic              wr_en;

    // Entry leaving the window: bypass, written entry, or the seed value
    always_comb begin
        pos_inc = (r_pos == PW'(DEPTH - 1)) ? '0 : r_pos + 1'b1;
        if (r_byp) begin
            old_val = r_byp_val;
        end else if (CW'(r_pos) < r_fill) begin
            old_val = r_rd;
        end else begin
            old_val = r_seed_val;
        end
    end

    // Seed on first value, otherwise replace the oldest entry
    always_comb begin
        n_seeded   = r_seeded;
        n_seed_val = r_seed_val;
        n_pos      = r_pos;
        n_fill     = r_fill;
        n_sum      = r_sum;
        wr_en      = 1'b0;
        if (i_push) begin
            if (!r_seeded) begin
                n_seeded   = 1'b1;
                n_seed_val = i_data;
                n_sum      = SUM_W'(i_data) * SUM_W'(DEPTH);
                n_pos      = '0;
                n_fill     = '0;
            end else begin
                wr_en  = 1'b1;
                n_sum  = r_sum - SUM_W'(old_val) + SUM_W'(i_data);
                n_pos  = pos_inc;
                n_fill = (r_fill == CW'(DEPTH)) ? r_fill : r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_pos    <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_byp    <= 1'b0;
        end else begin
            r_seeded <= n_seeded;
            r_pos    <= n_pos;
            r_fill   <= n_fill;
            r_sum    <= n_sum;
            r_byp    <= wr_en && (n_pos == r_pos);
        end
    end

    // Window memory: one write, one registered read of the next oldest entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= i_data;
        end
        r_rd       <= r_mem[n_pos];
        r_byp_val  <= i_data;
        r_seed_val <= n_seed_val;
    end

    assign o_sum = r_sum;

endmodule

// ===== src/fglf_fifo.sv =====
// Two-entry queue with valid/ready on both sides.
module fglf_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/fglf_front.sv =====
// Front end: takes transactions, keeps the ADC window sum, issues scans.
module fglf_front #(
    parameter int ADC_WINDOW = 20,
    parameter int ADC_SUM_W  = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fglf_pkg::t_in        i_in_data,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output logic [ADC_SUM_W-1:0] o_q_sum
);
    import fglf_pkg::*;

    logic                    accept;
    logic                    sample_push;
    logic                    scan;
    logic [SCAN_TIMER_W-1:0] r_scan_timer, n_scan_timer;
    logic [ADC_SUM_W-1:0]    adc_sum;

    assign o_in_ready  = i_q_ready;
    assign accept      = i_in_valid && i_q_ready;
    assign sample_push = accept && (i_in_data.opcode == OP_SAMPLE);

    // Scan timer: a scan runs on every SCAN_PERIOD-th tick
    always_comb begin
        n_scan_timer = r_scan_timer;
        scan         = 1'b0;
        if (accept && (i_in_data.opcode == OP_TICK)) begin
            if (r_scan_timer == SCAN_TIMER_W'(SCAN_PERIOD - 1)) begin
                scan         = 1'b1;
                n_scan_timer = '0;
            end else begin
                n_scan_timer = r_scan_timer + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_timer <= '0;
        end else begin
            r_scan_timer <= n_scan_timer;
        end
    end

    fglf_window #(
        .DEPTH  (ADC_WINDOW),
        .DATA_W (SAMPLE_W),
        .SUM_W  (ADC_SUM_W)
    ) u_adc_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sample_push),
        .i_data  (i_in_data.sample),
        .o_sum   (adc_sum)
    );

    // Scan job carries a snapshot of the ADC window sum
    assign o_q_valid = scan;
    assign o_q_sum   = adc_sum;

endmodule

// ===== src/fglf_back.sv =====
// Back end: scan sequencer, voltage average, level stepping, display writes.
module fglf_back #(
    parameter int ADC_WINDOW     = 20,
    parameter int VOLT_WINDOW    = 20,
    parameter int ADC_FULL_SCALE = 4096,
    parameter int ADC_SUM_W      = 17,
    parameter int VOLT_SUM_W     = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  logic [ADC_SUM_W-1:0]            i_q_sum,
    output logic                            o_w_valid,
    input  logic                            i_w_ready,
    output fglf_pkg::t_out                  o_w_data,
    input  logic                            i_cfg_we,
    input  logic [fglf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fglf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fglf_pkg::*;

    // Exact divide by constant: n / d == (n * ceil(2^(N+l)/d)) >> (N+l)
    localparam int ADC_L   = $clog2(ADC_WINDOW);
    localparam int ADC_S   = ADC_SUM_W + ADC_L;
    localparam int ADC_M_W = ADC_SUM_W + 2;
    localparam logic [63:0] ADC_M =
        ((64'd1 << ADC_S) + 64'(ADC_WINDOW) - 64'd1) / 64'(ADC_WINDOW);
    localparam int P1_W = ADC_SUM_W + ADC_M_W;

    localparam int SCALE_W = SAMPLE_W + MV_SPAN_W;
    localparam int FS_L    = $clog2(ADC_FULL_SCALE);
    localparam int FS_S    = SCALE_W + FS_L;
    localparam int FS_M_W  = SCALE_W + 2;
    localparam logic [63:0] FS_M =
        ((64'd1 << FS_S) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
    localparam int P3_W = SCALE_W + FS_M_W;

    localparam int VOLT_L   = $clog2(VOLT_WINDOW);
    localparam int VOLT_S   = VOLT_SUM_W + VOLT_L;
    localparam int VOLT_M_W = VOLT_SUM_W + 2;
    localparam logic [63:0] VOLT_M =
        ((64'd1 << VOLT_S) + 64'(VOLT_WINDOW) - 64'd1) / 64'(VOLT_WINDOW);
    localparam int P4_W = VOLT_SUM_W + VOLT_M_W;

    t_back_state r_state, n_state;

    // Configuration
    t_thr               r_thr;
    logic [TIMER_W-1:0] r_far;
    logic [TIMER_W-1:0] r_near;

    // Datapath products
    logic [P1_W-1:0]    r_p1;
    logic [SCALE_W-1:0] r_p2;
    logic [P3_W-1:0]    r_p3;
    logic [P4_W-1:0]    r_p4;

    // Display and step state
    logic               r_scan_seeded, n_scan_seeded;
    logic [LEVEL_W-1:0] r_lagged, n_lagged;
    logic               r_flag, n_flag;
    logic [TIMER_W-1:0] r_step, n_step;
    t_write             r_w1, n_w1;
    t_write             r_w2, n_w2;

    logic [SAMPLE_W-1:0]   avg;
    logic [SCALE_W-1:0]    mv_raw;
    logic [MV_W-1:0]       mv;
    logic [MV_W-1:0]       vavg;
    logic [VOLT_SUM_W-1:0] vsum;
    logic                  vpush;
    logic [LEVEL_W-1:0]    seed_lv;
    logic [LEVEL_W-1:0]    cur_lv;
    logic [LEVEL_W-1:0]    step_lv;
    logic [LEVEL_W-1:0]    diff;
    logic [TIMER_W-1:0]    step_sat;
    logic                  held;
    t_disp                 d1;
    t_disp                 d2;

    // Level 0..5 for the first threshold met, 6 below all
    function automatic logic [LEVEL_W-1:0] quantize(input logic [MV_W-1:0] v,
                                                    input t_thr thr);
        logic [LEVEL_W-1:0] lv;
        lv = LEVEL_W'(NUM_THR);
        for (int i = NUM_THR - 1; i >= 0; i--) begin
            if (v >= thr[i]) begin
                lv = LEVEL_W'(i);
            end
        end
        return lv;
    endfunction

    // Level 0 raises the warning once; any other level clears it
    function automatic t_disp disp(input logic [LEVEL_W-1:0] lv, input logic flag);
        t_disp d;
        if (lv == '0) begin
            d.en   = !flag;
            d.warn = 1'b1;
            d.flag = 1'b1;
        end else begin
            d.en   = 1'b1;
            d.warn = 1'b0;
            d.flag = 1'b0;
        end
        return d;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_far  <= FAR_WAIT_RESET;
            r_near <= NEAR_WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FAR_WAIT:  r_far  <= i_cfg_data;
                CFG_NEAR_WAIT: r_near <= i_cfg_data;
                default: begin
                    if (i_cfg_addr inside {[CFG_LEVEL0:CFG_LEVEL5]}) begin
                        r_thr[i_cfg_addr] <= i_cfg_data[MV_W-1:0];
                    end
                end
            endcase
        end
    end

    // Quotients and clipped millivolts
    always_comb begin
        avg    = SAMPLE_W'(r_p1 >> ADC_S);
        mv_raw = SCALE_W'(r_p3 >> FS_S);
        mv     = (mv_raw > SCALE_W'(MV_MAX)) ? MV_W'(MV_MAX) : mv_raw[MV_W-1:0];
        vavg   = MV_W'(r_p4 >> VOLT_S);
    end

    // Step decision
    always_comb begin
        seed_lv  = quantize(mv, r_thr);
        cur_lv   = quantize(vavg, r_thr);
        diff     = (cur_lv > r_lagged) ? cur_lv - r_lagged : r_lagged - cur_lv;
        step_sat = (r_step > TIMER_MAX - TIMER_W'(SCAN_PERIOD)) ?
                   TIMER_MAX : r_step + TIMER_W'(SCAN_PERIOD);
        held     = ((diff >= LEVEL_W'(2)) && (step_sat < r_far)) ||
                   ((diff == LEVEL_W'(1)) && (step_sat < r_near));
        if (cur_lv > r_lagged) begin
            step_lv = r_lagged + 1'b1;
        end else if (cur_lv < r_lagged) begin
            step_lv = r_lagged - 1'b1;
        end else begin
            step_lv = r_lagged;
        end
        d1 = disp(seed_lv, r_flag);
        d2 = disp(step_lv, r_flag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, handshakes and display state updates
    always_comb begin
        n_state       = r_state;
        n_scan_seeded = r_scan_seeded;
        n_lagged      = r_lagged;
        n_flag        = r_flag;
        n_step        = r_step;
        n_w1          = r_w1;
        n_w2          = r_w2;
        o_q_ready     = 1'b0;
        o_w_valid     = 1'b0;
        vpush         = 1'b0;
        o_w_data      = '{shown_level: r_w1.level, low_fuel_warning: r_w1.warn,
                          last: !r_w2.en};
        case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_state = ST_MV;
                end
            end
            ST_MV:    n_state = ST_SCALE;
            ST_SCALE: n_state = ST_VOLT;
            ST_VOLT: begin
                vpush   = 1'b1;
                n_w1.en = 1'b0;
                if (!r_scan_seeded) begin
                    n_scan_seeded = 1'b1;
                    n_lagged      = seed_lv;
                    n_flag        = d1.flag;
                    n_w1          = '{en: d1.en, level: seed_lv, warn: d1.warn};
                end
                n_state = ST_VAVG;
            end
            ST_VAVG: n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_w2.en = 1'b0;
                if (held) begin
                    n_step = step_sat;
                end else begin
                    n_step   = '0;
                    n_lagged = step_lv;
                    n_flag   = d2.flag;
                    n_w2     = '{en: d2.en, level: step_lv, warn: d2.warn};
                end
                n_state = ST_EMIT1;
            end
            ST_EMIT1: begin
                o_w_valid = r_w1.en;
                if (!r_w1.en || i_w_ready) begin
                    n_state = ST_EMIT2;
                end
            end
            ST_EMIT2: begin
                o_w_valid = r_w2.en;
                o_w_data  = '{shown_level: r_w2.level, low_fuel_warning: r_w2.warn,
                              last: 1'b1};
                if (!r_w2.en || i_w_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_seeded <= 1'b0;
            r_lagged      <= '0;
            r_flag        <= 1'b0;
            r_step        <= '0;
        end else begin
            r_scan_seeded <= n_scan_seeded;
            r_lagged      <= n_lagged;
            r_flag        <= n_flag;
            r_step        <= n_step;
        end
    end

    // Multiplier chain, one product per state
    always_ff @(posedge i_clk) begin
        r_w1 <= n_w1;
        r_w2 <= n_w2;
        if (r_state == ST_IDLE) begin
            r_p1 <= P1_W'(i_q_sum) * P1_W'(ADC_M);
        end
        if (r_state == ST_MV) begin
            r_p2 <= SCALE_W'(avg) * SCALE_W'(MV_SPAN);
        end
        if (r_state == ST_SCALE) begin
            r_p3 <= P3_W'(r_p2) * P3_W'(FS_M);
        end
        if (r_state == ST_VAVG) begin
            r_p4 <= P4_W'(vsum) * P4_W'(VOLT_M);
        end
    end

    fglf_window #(
        .DEPTH  (VOLT_WINDOW),
        .DATA_W (MV_W),
        .SUM_W  (VOLT_SUM_W)
    ) u_volt_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (vpush),
        .i_data  (mv),
        .o_sum   (vsum)
    );

endmodule

// ===== src/fuel_gauge_level_filter_top.sv =====
// Top level of the fuel gauge level filter.
//
// The block takes one transaction per clock: ADC samples update a windowed
// running sum (one memory write and one prefetch read per cycle), and ticks
// advance the scan timer, so input ready stays high whenever the two-entry
// scan queue has room. Every 200th tick queues a scan; the back-end
// sequencer runs each scan through its multiplier chain (ADC average,
// millivolt scale, voltage average) and then through the display write
// slots, which wait while the output queue is full. Results leave through a
// two-entry output queue, so input stalls only when results back up. After
// reset there is no clearing pass; the first sample seeds the ADC window.
module fuel_gauge_level_filter_top #(
    parameter int ADC_WINDOW     = 20,
    parameter int VOLT_WINDOW    = 20,
    parameter int ADC_FULL_SCALE = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fglf_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fglf_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fglf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fglf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fglf_pkg::*;

    localparam int ADC_SUM_W  = $clog2(((2 ** SAMPLE_W) - 1) * ADC_WINDOW + 1);
    localparam int VOLT_SUM_W = $clog2(MV_MAX * VOLT_WINDOW + 1);

    logic                 fq_valid;
    logic                 fq_ready;
    logic [ADC_SUM_W-1:0] fq_sum;
    logic                 bq_valid;
    logic                 bq_ready;
    logic [ADC_SUM_W-1:0] bq_sum;
    logic                 w_valid;
    logic                 w_ready;
    t_out                 w_data;

    fglf_front #(
        .ADC_WINDOW (ADC_WINDOW),
        .ADC_SUM_W  (ADC_SUM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_sum    (fq_sum)
    );

    // Scan queue between front and back
    fglf_fifo #(
        .DATA_W (ADC_SUM_W)
    ) u_scan_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_sum),
        .o_valid (bq_valid),
        .i_ready (bq_ready),
        .o_data  (bq_sum)
    );

    fglf_back #(
        .ADC_WINDOW     (ADC_WINDOW),
        .VOLT_WINDOW    (VOLT_WINDOW),
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .ADC_SUM_W      (ADC_SUM_W),
        .VOLT_SUM_W     (VOLT_SUM_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (bq_valid),
        .o_q_ready  (bq_ready),
        .i_q_sum    (bq_sum),
        .o_w_valid  (w_valid),
        .i_w_ready  (w_ready),
        .o_w_data   (w_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Output queue decouples display writes from the consumer
    fglf_fifo #(
        .DATA_W ($bits(t_out))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_ready (w_ready),
        .i_data  (w_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== src/fglf_checker.sv =====
// Port-level assertions for the fuel gauge level filter, bound to the top.
module fglf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input fglf_pkg::t_out o_out_data
);
    import fglf_pkg::*;

    // Reset empties both queues
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("queues not empty after reset");

    // Warning is set exactly on writes of level 0
    a_warn_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.shown_level == '0) == o_out_data.low_fuel_warning))
        else $error("warning flag does not match shown level");

    // Shown level never exceeds 6
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.shown_level != 3'd7))
        else $error("shown level out of range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

endmodule

bind fuel_gauge_level_filter_top fglf_checker u_fglf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
